### rtl/core/cnb_pkg.sv
// cnb_pkg: shared types and constants for the categorical naive Bayes block.
// Command and result beat structs, command codes, inter-module control structs.
// No dependencies.
package cnb_pkg;

    localparam int CNT_W  = 5;
    localparam int CODE_W = 8;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [CODE_W-1:0] feat0;
        logic [CODE_W-1:0] feat1;
        logic [CODE_W-1:0] feat2;
        logic [CODE_W-1:0] feat3;
        logic              train_label;
    } t_cmd;

    typedef struct packed {
        logic              predicted_label;
        logic [CNT_W-1:0]  class1_rows;
        logic [CNT_W-1:0]  class0_rows;
        logic [CNT_W-1:0]  match1_f0;
        logic [CNT_W-1:0]  match1_f1;
        logic [CNT_W-1:0]  match1_f2;
        logic [CNT_W-1:0]  match1_f3;
        logic [CNT_W-1:0]  match0_f0;
        logic [CNT_W-1:0]  match0_f1;
        logic [CNT_W-1:0]  match0_f2;
        logic [CNT_W-1:0]  match0_f3;
    } t_res;

    // tally control: clear at query start, accumulate on a valid row read
    typedef struct packed {
        logic clr;
        logic vld;
    } t_tally_ctl;

    // compare unit status
    typedef struct packed {
        logic done;
        logic gt;
    } t_cmp_sts;

endpackage

### rtl/core/cnb_ram.sv
// cnb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cnb_ram #(
    parameter int W = 33,
    parameter int D = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic                                 i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/cnb_tally.sv
// cnb_tally: per-feature, per-class match counters and class row counters.
// Fed one stored row per beat from the row RAM. Depends on cnb_pkg.
module cnb_tally #(
    parameter int NF = 4,
    parameter int FB = 8,
    parameter int CW = 5
) (
    input  logic                   i_clk,
    input  cnb_pkg::t_tally_ctl    i_ctl,
    input  logic [NF*FB:0]         i_row,
    input  logic [NF*FB-1:0]       i_query,
    output logic [CW-1:0]          o_m1 [4],
    output logic [CW-1:0]          o_m0 [4],
    output logic [CW-1:0]          o_c1,
    output logic [CW-1:0]          o_c0
);
    import cnb_pkg::*;

    logic [CW-1:0] r_c1;
    logic [CW-1:0] r_c0;
    logic          w_label;

    assign w_label = i_row[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_c1 <= '0;
            r_c0 <= '0;
        end else if (i_ctl.vld) begin
            if (w_label) begin
                r_c1 <= r_c1 + CW'(1);
            end else begin
                r_c0 <= r_c0 + CW'(1);
            end
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_feat
        if (j < NF) begin : g_used
            logic [CW-1:0] r_hit1;
            logic [CW-1:0] r_hit0;
            logic          w_eq;

            assign w_eq = (i_row[1 + j*FB +: FB] == i_query[j*FB +: FB]);

            always_ff @(posedge i_clk) begin
                if (i_ctl.clr) begin
                    r_hit1 <= '0;
                    r_hit0 <= '0;
                end else if (i_ctl.vld && w_eq) begin
                    if (w_label) begin
                        r_hit1 <= r_hit1 + CW'(1);
                    end else begin
                        r_hit0 <= r_hit0 + CW'(1);
                    end
                end
            end

            assign o_m1[j] = r_hit1;
            assign o_m0[j] = r_hit0;
        end else begin : g_unused
            assign o_m1[j] = '0;
            assign o_m0[j] = '0;
        end
    end

    assign o_c1 = r_c1;
    assign o_c0 = r_c0;
endmodule

### rtl/core/cnb_cmp.sv
// cnb_cmp: sequential exact likelihood compare by cross-multiplication.
// One factor per side per cycle; prod(m1)*c0^NF against prod(m0)*c1^NF.
// Depends on cnb_pkg.
module cnb_cmp #(
    parameter int NF = 4,
    parameter int CW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CW-1:0]      i_m1 [4],
    input  logic [CW-1:0]      i_m0 [4],
    input  logic [CW-1:0]      i_c1,
    input  logic [CW-1:0]      i_c0,
    output cnb_pkg::t_cmp_sts  o_sts
);
    import cnb_pkg::*;

    localparam int         ACC_W = 2 * NF * CW;
    localparam logic [1:0] LAST  = 2'(NF - 1);

    logic [ACC_W-1:0]    r_lhs;
    logic [ACC_W-1:0]    r_rhs;
    logic [1:0]          r_j;
    logic                r_ph;
    logic                r_run;
    logic                r_fin;
    t_cmp_sts            r_sts;
    logic [CW-1:0]       w_fac_l;
    logic [CW-1:0]       w_fac_r;
    logic [ACC_W+CW-1:0] w_prod_l;
    logic [ACC_W+CW-1:0] w_prod_r;

    // even phase: match count of feature r_j; odd phase: other class size
    assign w_fac_l  = r_ph ? i_c0 : i_m1[r_j];
    assign w_fac_r  = r_ph ? i_c1 : i_m0[r_j];
    assign w_prod_l = r_lhs * w_fac_l;
    assign w_prod_r = r_rhs * w_fac_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fin <= 1'b0;
            r_sts <= '0;
        end else begin
            if (i_start) begin
                r_run      <= 1'b1;
                r_fin      <= 1'b0;
                r_sts.done <= 1'b0;
            end else if (r_run && r_ph && (r_j == LAST)) begin
                r_run      <= 1'b0;
                r_fin      <= 1'b1;
                r_sts.done <= 1'b0;
            end else if (r_fin) begin
                r_fin      <= 1'b0;
                r_sts.done <= 1'b1;
                r_sts.gt   <= (i_c1 != '0) && (i_c0 != '0) && (r_lhs > r_rhs);
            end else begin
                r_sts.done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lhs <= ACC_W'(1);
            r_rhs <= ACC_W'(1);
            r_j   <= 2'd0;
            r_ph  <= 1'b0;
        end else if (r_run) begin
            r_lhs <= w_prod_l[ACC_W-1:0];
            r_rhs <= w_prod_r[ACC_W-1:0];
            r_ph  <= ~r_ph;
            if (r_ph) begin
                r_j <= r_j + 2'd1;
            end
        end
    end

    assign o_sts = r_sts;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_run && !r_fin)
        else $error("compare started while running");
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sts.done) |-> $past(r_fin))
        else $error("done without final step");
    a_run_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_fin))
        else $error("run and final overlap");
`endif
endmodule

### rtl/core/categorical_naive_bayes_classifier.sv
// categorical_naive_bayes_classifier: two-class categorical naive Bayes, top level.
// Holds the row RAM, command FSM and row walk; uses cnb_ram, cnb_tally, cnb_cmp
// and cnb_pkg.
//
//  channel   | ports                 | handshake
//  ----------+-----------------------+----------------------------------------
//  command   | start, busy, i_cmd    | beat taken at edge with start & !busy
//  result    | o_done, o_res         | one-cycle strobe, no back-pressure
//
// Load and clear never raise busy; busy stays low after them.
// A query holds busy through the row walk and the compare: one RAM read per
// stored row (single read port, registered read data), then one multiply step
// per factor on each side of the compare. The result strobes in the same cycle
// that busy drops. Synchronous active-low reset empties the table at once; the
// row RAM itself is not cleared. The result side cannot stall.
module categorical_naive_bayes_classifier #(
    parameter int MAX_ROWS     = 16,
    parameter int NUM_FEATURES = 4,
    parameter int FEATURE_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cnb_pkg::t_cmd i_cmd,
    output logic          o_done,
    output cnb_pkg::t_res o_res
);
    import cnb_pkg::*;

    localparam int CW = $clog2(MAX_ROWS + 1);          // holds 0..MAX_ROWS
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW = NUM_FEATURES * FEATURE_BITS;
    localparam int RW = QW + 1;                        // codes plus label
    localparam logic [CW-1:0] ROWS_MAX = CW'(MAX_ROWS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_rows;           // rows held
    logic [CW-1:0] n_rows;
    logic [CW-1:0] r_addr;           // next row to read during the walk
    logic [CW-1:0] n_addr;
    logic          r_rvld;           // RAM read data valid this cycle
    logic [QW-1:0] r_query;
    logic          r_done;
    t_res          r_res;

    logic          w_acc;
    logic          w_we;
    logic          w_re;
    logic          w_cmp_go;
    logic [7:0]    w_feat [4];
    logic [QW-1:0] w_codes;
    logic [RW-1:0] w_rdata;
    t_tally_ctl    w_tctl;
    t_cmp_sts      w_sts;
    logic [CW-1:0] w_m1 [4];
    logic [CW-1:0] w_m0 [4];
    logic [CW-1:0] w_c1;
    logic [CW-1:0] w_c0;

    assign busy  = (r_state != S_IDLE);
    assign w_acc = start && !busy;

    assign w_feat[0] = i_cmd.feat0;
    assign w_feat[1] = i_cmd.feat1;
    assign w_feat[2] = i_cmd.feat2;
    assign w_feat[3] = i_cmd.feat3;

    // only the low FEATURE_BITS of each code count
    always_comb begin
        w_codes = '0;
        for (int j = 0; j < NUM_FEATURES; j++) begin
            w_codes[j*FEATURE_BITS +: FEATURE_BITS] = FEATURE_BITS'(w_feat[j]);
        end
    end

    // loads past capacity are dropped
    assign w_we = w_acc && (i_cmd.func == FUNC_LOAD) && (r_rows != ROWS_MAX);
    assign w_re = (r_state == S_WALK) && (r_addr != r_rows);

    // walk is over once every row was issued and the last read came back
    assign w_cmp_go = (r_state == S_WALK) && (r_addr == r_rows) && !r_rvld;

    always_comb begin
        n_state = r_state;
        n_rows  = r_rows;
        n_addr  = r_addr;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_cmd.func)
                        FUNC_LOAD: begin
                            if (w_we) begin
                                n_rows = r_rows + CW'(1);
                            end
                        end
                        FUNC_QUERY: begin
                            n_state = S_WALK;
                            n_addr  = '0;
                        end
                        FUNC_CLEAR: begin
                            n_rows = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_re) begin
                    n_addr = r_addr + CW'(1);
                end
                if (w_cmp_go) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (w_sts.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rows  <= '0;
            r_rvld  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rows  <= n_rows;
            r_rvld  <= w_re;
            r_done  <= (r_state == S_MUL) && w_sts.done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (w_acc && (i_cmd.func == FUNC_QUERY)) begin
            r_query <= w_codes;
        end
        if ((r_state == S_MUL) && w_sts.done) begin
            r_res.predicted_label <= w_sts.gt;
            r_res.class1_rows     <= CNT_W'(w_c1);
            r_res.class0_rows     <= CNT_W'(w_c0);
            r_res.match1_f0       <= CNT_W'(w_m1[0]);
            r_res.match1_f1       <= CNT_W'(w_m1[1]);
            r_res.match1_f2       <= CNT_W'(w_m1[2]);
            r_res.match1_f3       <= CNT_W'(w_m1[3]);
            r_res.match0_f0       <= CNT_W'(w_m0[0]);
            r_res.match0_f1       <= CNT_W'(w_m0[1]);
            r_res.match0_f2       <= CNT_W'(w_m0[2]);
            r_res.match0_f3       <= CNT_W'(w_m0[3]);
        end
    end

    cnb_ram #(
        .W (RW),
        .D (MAX_ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_rows[AW-1:0]),
        .i_wdata ({w_codes, i_cmd.train_label}),
        .i_re    (w_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_tctl.clr = w_acc && (i_cmd.func == FUNC_QUERY);
    assign w_tctl.vld = r_rvld;

    cnb_tally #(
        .NF (NUM_FEATURES),
        .FB (FEATURE_BITS),
        .CW (CW)
    ) u_tally (
        .i_clk   (i_clk),
        .i_ctl   (w_tctl),
        .i_row   (w_rdata),
        .i_query (r_query),
        .o_m1    (w_m1),
        .o_m0    (w_m0),
        .o_c1    (w_c1),
        .o_c0    (w_c0)
    );

    cnb_cmp #(
        .NF (NUM_FEATURES),
        .CW (CW)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cmp_go),
        .i_m1    (w_m1),
        .i_m0    (w_m0),
        .i_c1    (w_c1),
        .i_c0    (w_c0),
        .o_sts   (w_sts)
    );

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef ASSERT_OFF
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows <= ROWS_MAX)
        else $error("row count beyond capacity");
    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_addr <= r_rows))
        else $error("walk address past stored rows");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_cmd.func == FUNC_QUERY)) |=> busy)
        else $error("query accepted but block not busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");
    a_rows_walk_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_rows))
        else $error("row count changed during a query");
`endif
endmodule
